FILE: design/oes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oes_pkg
// Shared constants and types for the octal escape sanitizer.
// ----------------------------------------------------------------------------
package oes_pkg;

  localparam logic [7:0] BSL_CH   = 8'h5C;
  localparam logic [7:0] ZERO_CH  = 8'h30;
  localparam logic [7:0] THREE_CH = 8'h33;
  localparam logic [7:0] SEVEN_CH = 8'h37;
  localparam logic [7:0] SPACE_CH = 8'h20;

  localparam int MAX_RESULTS = 4;
  localparam int QUEUE_DEPTH = 4;

  // what is waiting behind a backslash
  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_BSL  = 2'd1,
    HELD_ONE  = 2'd2,
    HELD_TWO  = 2'd3
  } held_t;

  // a group of output words made from one input word
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [1:0]                  last;
    logic                        fin;
  } entry_t;

endpackage
`default_nettype wire

FILE: design/oes_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oes_front
// Classifies each input word against the held escape window and builds the
// group of output words it releases.
// ----------------------------------------------------------------------------
module oes_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_final,
  input  wire logic           q_full,
  output logic                q_push,
  output oes_pkg::entry_t     q_data
);

  oes_pkg::held_t held;
  oes_pkg::held_t held_next;
  logic [7:0] d0;
  logic [7:0] d1;
  logic [7:0] d0_next;
  logic [7:0] d1_next;

  logic [oes_pkg::MAX_RESULTS-1:0][7:0] res;
  logic [2:0] n;
  logic [1:0] flush_n;
  logic [2:0][7:0] fl;
  logic is_oct;
  logic is_lead;
  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    res       = '0;
    n         = 3'd0;
    held_next = oes_pkg::HELD_NONE;
    d0_next   = d0;
    d1_next   = d1;
    is_oct    = in_byte inside {[oes_pkg::ZERO_CH:oes_pkg::SEVEN_CH]};
    is_lead   = in_byte inside {[oes_pkg::ZERO_CH:oes_pkg::THREE_CH]};
    case (held)
      oes_pkg::HELD_NONE: begin
        if (in_byte == oes_pkg::BSL_CH) begin
          held_next = oes_pkg::HELD_BSL;
        end else begin
          res[0] = in_byte;
          n      = 3'd1;
        end
      end
      oes_pkg::HELD_BSL: begin
        if (in_byte == oes_pkg::BSL_CH) begin
          res[0] = oes_pkg::BSL_CH;
          res[1] = oes_pkg::BSL_CH;
          n      = 3'd2;
        end else if (is_lead) begin
          d0_next   = in_byte;
          held_next = oes_pkg::HELD_ONE;
        end else begin
          res[0] = oes_pkg::SPACE_CH;
          res[1] = in_byte;
          n      = 3'd2;
        end
      end
      oes_pkg::HELD_ONE: begin
        if (is_oct) begin
          d1_next   = in_byte;
          held_next = oes_pkg::HELD_TWO;
        end else begin
          res[0] = oes_pkg::SPACE_CH;
          res[1] = d0;
          if (in_byte == oes_pkg::BSL_CH) begin
            n         = 3'd2;
            held_next = oes_pkg::HELD_BSL;
          end else begin
            res[2] = in_byte;
            n      = 3'd3;
          end
        end
      end
      oes_pkg::HELD_TWO: begin
        res[1] = d0;
        res[2] = d1;
        if (is_oct) begin
          res[0] = oes_pkg::BSL_CH;
          res[3] = in_byte;
          n      = 3'd4;
        end else begin
          res[0] = oes_pkg::SPACE_CH;
          if (in_byte == oes_pkg::BSL_CH) begin
            n         = 3'd3;
            held_next = oes_pkg::HELD_BSL;
          end else begin
            res[3] = in_byte;
            n      = 3'd4;
          end
        end
      end
      default: begin
      end
    endcase

    // end of string: lone backslash as space, then the held digits
    fl[0]   = oes_pkg::SPACE_CH;
    fl[1]   = d0_next;
    fl[2]   = d1_next;
    flush_n = in_final ? held_next : 2'd0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < flush_n) begin
        res[n[1:0]] = fl[k];
        n           = n + 3'd1;
      end
    end

    q_data.bytes = res;
    q_data.last  = 2'(n - 3'd1);
    q_data.fin   = in_final;
    q_push       = accept && (n != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= oes_pkg::HELD_NONE;
    end else if (accept) begin
      held <= in_final ? oes_pkg::HELD_NONE : held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d0 <= d0_next;
      d1 <= d1_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/oes_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oes_queue
// Short register queue of word groups between front and back.
// ----------------------------------------------------------------------------
module oes_queue #(
  parameter int DEPTH = oes_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire oes_pkg::entry_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output oes_pkg::entry_t     head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  oes_pkg::entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: design/oes_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oes_back
// Takes word groups off the queue and sends them out one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module oes_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire oes_pkg::entry_t q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 run_end,
  output logic                 string_end
);

  oes_pkg::entry_t cur;
  logic cur_valid;
  logic [1:0] idx;
  logic last_word;
  logic take;
  logic done;

  assign last_word  = (idx == cur.last);
  assign take       = cur_valid && out_ready;
  // current group finished or slot empty: load the next one
  assign done       = !cur_valid || (take && last_word);
  assign q_pop      = done && q_valid;

  assign out_valid  = cur_valid;
  assign out_byte   = cur.bytes[idx];
  assign run_end    = last_word;
  assign string_end = last_word && cur.fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (done) begin
      cur_valid <= q_valid;
      idx       <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

endmodule
`default_nettype wire

FILE: design/octal_escape_sanitizer_top.sv
`default_nettype none
// Path: each output word is registered in the word-group queue and then in the output slot.
// Throughput: one input word per cycle; the back end sends one output word per cycle
// while out_ready is high, so the k words released by one input word go out one after another.
// Input stalls only when the word-group queue (QUEUE_DEPTH entries) is full.
// Reset: synchronous, active high; clears the escape window, queue and output slot.
// ----------------------------------------------------------------------------
// octal_escape_sanitizer_top
// Replaces a backslash that starts no valid octal escape or doubled backslash
// by a space, passing all other bytes through in order.
// ----------------------------------------------------------------------------
module octal_escape_sanitizer_top #(
  parameter int QUEUE_DEPTH = oes_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_final,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            run_end,
  output logic            string_end
);

  oes_pkg::entry_t push_data;
  oes_pkg::entry_t head;
  logic push;
  logic full;
  logic pop;
  logic not_empty;

  oes_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_final (in_final),
    .q_full   (full),
    .q_push   (push),
    .q_data   (push_data)
  );

  oes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  oes_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (not_empty),
    .q_head     (head),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end)
  );

endmodule
`default_nettype wire

FILE: design/oes_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oes_checker
// Port-level checks on the octal escape sanitizer.
// ----------------------------------------------------------------------------
module oes_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_byte,
  input wire logic       in_final,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       run_end,
  input wire logic       string_end
);

  // stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_final))
    else $error("input word changed while stalled");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(run_end) && $stable(string_end))
    else $error("output word changed while stalled");

  // end of string always closes the group of its input word
  a_end_group: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_end)
    else $error("string end without run end");

  // a full queue means the output slot is busy
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with idle output");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind octal_escape_sanitizer_top oes_checker u_checker (.*);
`default_nettype wire

FILE: bench/tb_octal_escape_sanitizer_top.sv
// ----------------------------------------------------------------------------
// tb_octal_escape_sanitizer_top
// Self-checking bench for the octal escape sanitizer. Strings of bytes are
// streamed in, mostly with random gaps while the output side stalls at random. A
// behavioral copy of the escape window predicts every output word, and each
// one is checked in order against what the block sends.
// ----------------------------------------------------------------------------
module tb_octal_escape_sanitizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 340;
  localparam int NOISE_WORDS  = 60;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
  } clean_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_final = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  // predictor state: what sits behind a pending backslash
  oes_pkg::held_t held_state = oes_pkg::HELD_NONE;
  logic [7:0]  held_d0 = 8'h00;
  logic [7:0]  held_d1 = 8'h00;
  clean_word_t clean_q[$];

  int  error_count   = 0;
  int  words_sent    = 0;
  int  strings_sent  = 0;
  int  words_checked = 0;
  int  cycle_count   = 0;
  bit  gaps_on       = 1'b0;
  bit  stalls_on     = 1'b0;
  int  stall_left    = 0;

  octal_escape_sanitizer_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_final   (in_final),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, clean_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit is_octal(logic [7:0] b);
    return b >= oes_pkg::ZERO_CH && b <= oes_pkg::SEVEN_CH;
  endfunction

  function automatic bit is_lead(logic [7:0] b);
    return b >= oes_pkg::ZERO_CH && b <= oes_pkg::THREE_CH;
  endfunction

  // a byte seen with nothing pending: a backslash opens a window
  function automatic void look_fresh(ref logic [7:0] outs[$], input logic [7:0] b);
    if (b == oes_pkg::BSL_CH) held_state = oes_pkg::HELD_BSL;
    else outs.push_back(b);
  endfunction

  task automatic sanitize_word(input logic [7:0] b, input logic fin);
    logic [7:0]     outs[$];
    oes_pkg::held_t was;
    clean_word_t    w;
    was = held_state;
    held_state = oes_pkg::HELD_NONE;
    case (was)
      oes_pkg::HELD_NONE: look_fresh(outs, b);
      oes_pkg::HELD_BSL: begin
        if (b == oes_pkg::BSL_CH) begin
          outs.push_back(oes_pkg::BSL_CH);
          outs.push_back(oes_pkg::BSL_CH);
        end else if (is_lead(b)) begin
          held_d0 = b;
          held_state = oes_pkg::HELD_ONE;
        end else begin
          outs.push_back(oes_pkg::SPACE_CH);
          outs.push_back(b);
        end
      end
      oes_pkg::HELD_ONE: begin
        if (is_octal(b)) begin
          held_d1 = b;
          held_state = oes_pkg::HELD_TWO;
        end else begin
          outs.push_back(oes_pkg::SPACE_CH);
          outs.push_back(held_d0);
          look_fresh(outs, b);
        end
      end
      default: begin
        if (is_octal(b)) begin
          outs.push_back(oes_pkg::BSL_CH);
          outs.push_back(held_d0);
          outs.push_back(held_d1);
          outs.push_back(b);
        end else begin
          outs.push_back(oes_pkg::SPACE_CH);
          outs.push_back(held_d0);
          outs.push_back(held_d1);
          look_fresh(outs, b);
        end
      end
    endcase
    // end of string flushes the window, cut-short escape becomes space + digits
    if (fin) begin
      if (held_state != oes_pkg::HELD_NONE) outs.push_back(oes_pkg::SPACE_CH);
      if (held_state == oes_pkg::HELD_ONE || held_state == oes_pkg::HELD_TWO)
        outs.push_back(held_d0);
      if (held_state == oes_pkg::HELD_TWO) outs.push_back(held_d1);
      held_state = oes_pkg::HELD_NONE;
    end
    foreach (outs[i]) begin
      w.data       = outs[i];
      w.run_end    = (i == outs.size() - 1);
      w.string_end = (i == outs.size() - 1) && fin;
      clean_q.push_back(w);
    end
  endtask

  // output side: random stalls, with stretches of none
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    clean_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (clean_q.size() == 0) begin
        $error("unexpected word out_byte=%02h run_end=%0b string_end=%0b",
               out_byte, run_end, string_end);
        error_count++;
      end else begin
        w = clean_q.pop_front();
        words_checked++;
        if (out_byte !== w.data) begin
          $error("out_byte: expected %02h, got %02h", w.data, out_byte);
          error_count++;
        end
        if (run_end !== w.run_end) begin
          $error("run_end: expected %0b, got %0b", w.run_end, run_end);
          error_count++;
        end
        if (string_end !== w.string_end) begin
          $error("string_end: expected %0b, got %0b", w.string_end, string_end);
          error_count++;
        end
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic fin);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_final <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sanitize_word(b, fin);
    words_sent++;
  endtask

  task automatic send_string(input logic [7:0] s[$]);
    foreach (s[i]) send_word(s[i], i == s.size() - 1);
    strings_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // one piece of a plausible escaped string
  task automatic add_token(ref logic [7:0] s[$]);
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: s.push_back(8'($urandom_range(0, 255)));
      3, 4: begin
        s.push_back(oes_pkg::BSL_CH);
        s.push_back(oes_pkg::ZERO_CH + 8'($urandom_range(0, 3)));
        s.push_back(oes_pkg::ZERO_CH + 8'($urandom_range(0, 7)));
        s.push_back(oes_pkg::ZERO_CH + 8'($urandom_range(0, 7)));
      end
      5: begin
        s.push_back(oes_pkg::BSL_CH);
        s.push_back(oes_pkg::BSL_CH);
      end
      6: begin
        // broken escape: digits and near-digits after a backslash
        s.push_back(oes_pkg::BSL_CH);
        n = $urandom_range(0, 3);
        repeat (n) s.push_back(8'($urandom_range(8'h2E, 8'h39)));
      end
      7: begin
        case ($urandom_range(0, 5))
          0: s.push_back(oes_pkg::ZERO_CH - 8'd1);
          1: s.push_back(oes_pkg::ZERO_CH);
          2: s.push_back(oes_pkg::THREE_CH);
          3: s.push_back(oes_pkg::THREE_CH + 8'd1);
          4: s.push_back(oes_pkg::SEVEN_CH);
          default: s.push_back(oes_pkg::SEVEN_CH + 8'd1);
        endcase
      end
      8: s.push_back(oes_pkg::BSL_CH);
      default: s.push_back($urandom_range(0, 1) ? 8'h00 : 8'hFF);
    endcase
  endtask

  task automatic test_directed_escapes();
    logic [7:0] s[$];
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    s = '{8'h00, 8'hFF, 8'h41};                                  send_string(s);
    s = '{oes_pkg::BSL_CH, oes_pkg::BSL_CH};                     send_string(s);
    s = '{oes_pkg::BSL_CH, 8'h31, 8'h30, 8'h31};                 send_string(s);
    s = '{oes_pkg::BSL_CH, 8'h78};                               send_string(s);
    s = '{oes_pkg::BSL_CH, 8'h34};                               send_string(s);
    s = '{oes_pkg::BSL_CH, 8'h31, oes_pkg::BSL_CH};              send_string(s);
    s = '{oes_pkg::BSL_CH, 8'h32, 8'h37, oes_pkg::BSL_CH};       send_string(s);
    release_input();
  endtask

  task automatic test_directed_string_end();
    logic [7:0] s[$];
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    s = '{oes_pkg::BSL_CH};                                      send_string(s);
    s = '{oes_pkg::BSL_CH, oes_pkg::THREE_CH};                   send_string(s);
    s = '{oes_pkg::BSL_CH, oes_pkg::THREE_CH, oes_pkg::SEVEN_CH}; send_string(s);
    release_input();
  endtask

  task automatic test_random_strings();
    logic [7:0] s[$];
    int target;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      s.delete();
      repeat ($urandom_range(1, 5)) add_token(s);
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      send_string(s);
    end
    release_input();
  endtask

  task automatic test_random_noise();
    int i;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    for (i = 0; i < NOISE_WORDS; i++) begin
      if (i == NOISE_WORDS - 1) begin
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      end
    end
    strings_sent++;
    release_input();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_escapes();
    test_directed_string_end();
    test_random_strings();
    test_random_noise();

    stalls_on = 1'b0;
    wait (clean_q.size() == 0);
    repeat (60) @(posedge clk);

    $display("sent %0d words in %0d strings with random gaps and output stalls",
             words_sent, strings_sent);
    $display("checked %0d output words, %0d mismatches", words_checked, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
